// ===== hdl/hmf_pkg.sv =====
// Package for the Hill-type muscle force step: sequencer codes, command
// struct and fixed-point constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hmf_pkg;

  typedef enum logic [4:0] {
    ST_IDLE, ST_T1, ST_T2, ST_T3, ST_T4, ST_T5, ST_T6, ST_T7, ST_T8,
    ST_D1, ST_D2, ST_D3,
    ST_I1, ST_I2, ST_I3, ST_I4, ST_I5, ST_I6, ST_I7, ST_I8
  } step_t;

  typedef struct packed {
    step_t step;
    logic  load;
    logic  store;
  } hmf_cmd_t;

  localparam logic signed [32:0] TW_B1  = 33'sd2822753;
  localparam logic signed [32:0] TW_2A  = 33'sd2077080760;
  localparam logic signed [32:0] TW_ASQ = 33'sd1004492976;

  // n / 50 with n = hi * 2^24 + lo: 2^24 = 50 * DIV_CHUNK + 16,
  // remaining part (16 * hi + lo) divided by multiplying with ceil(2^33 / 50)
  localparam logic signed [32:0] DIV_RCP   = 33'sd171798692;
  localparam logic signed [32:0] DIV_CHUNK = 33'sd335544;

endpackage
`default_nettype wire

// ===== hdl/hill_muscle_force_step.sv =====
// Top level of the Hill-type muscle force step; ties the sequencer to the
// datapath. Depends on hmf_pkg, hmf_ctrl, hmf_dp.
//
// One sample in, one force out. From acceptance to result a sample passes
// through eight steps for the twitch filter and length weight on the single
// shared 33x33 multiplier, three steps for the divide by 50 by reciprocal
// multiplication, and eight steps for the Euler increment. The input is ready
// only while idle, so a new sample can be taken only once the previous result
// is in the output register; the last step holds while the output register
// still has a beat waiting.
`timescale 1ns / 1ps
`default_nettype none
module hill_muscle_force_step import hmf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_spike_in,
  input  wire logic signed [31:0] in_muscle_length,
  input  wire logic signed [31:0] in_length_velocity,
  input  wire logic [47:0]        in_sample_time,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_muscle_force
);

  hmf_cmd_t cmd;

  hmf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  hmf_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_spike_in        (in_spike_in),
    .in_muscle_length   (in_muscle_length),
    .in_length_velocity (in_length_velocity),
    .in_sample_time     (in_sample_time),
    .out_muscle_force   (out_muscle_force)
  );

endmodule
`default_nettype wire

// ===== hdl/hmf_ctrl.sv =====
// Sequencer for the muscle force step: handshakes and step order.
// Depends on hmf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hmf_ctrl import hmf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output hmf_cmd_t      cmd
);

  step_t      state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.step    = state_r;
    cmd.load    = 1'b0;
    cmd.store   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_T1;
        end
      end
      ST_T1: state_nxt = ST_T2;
      ST_T2: state_nxt = ST_T3;
      ST_T3: state_nxt = ST_T4;
      ST_T4: state_nxt = ST_T5;
      ST_T5: state_nxt = ST_T6;
      ST_T6: state_nxt = ST_T7;
      ST_T7: state_nxt = ST_T8;
      ST_T8: state_nxt = ST_D1;
      ST_D1: state_nxt = ST_D2;
      ST_D2: state_nxt = ST_D3;
      ST_D3: state_nxt = ST_I1;
      ST_I1: state_nxt = ST_I2;
      ST_I2: state_nxt = ST_I3;
      ST_I3: state_nxt = ST_I4;
      ST_I4: state_nxt = ST_I5;
      ST_I5: state_nxt = ST_I6;
      ST_I6: state_nxt = ST_I7;
      ST_I7: state_nxt = ST_I8;
      ST_I8: begin
        if (!out_valid_r || out_ready) begin
          cmd.store = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = cmd.store | (out_valid_r & ~out_ready);
  end

  assign out_valid = out_valid_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_T1)
    else $error("accepted beat did not start the sequence");

  a_result_from_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_I8))
    else $error("result appeared outside the final step");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before acceptance");

endmodule
`default_nettype wire

// ===== hdl/hmf_dp.sv =====
// Datapath for the muscle force step: shared multiplier, accumulator,
// reciprocal divide by 50 and state registers. Depends on hmf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hmf_dp import hmf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  hmf_cmd_t                cmd,
  input  wire logic signed [31:0] in_spike_in,
  input  wire logic signed [31:0] in_muscle_length,
  input  wire logic signed [31:0] in_length_velocity,
  input  wire logic [47:0]        in_sample_time,
  output logic signed [31:0]      out_muscle_force
);

  localparam logic signed [31:0] SMAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] SMIN = 32'sh80000000;

  logic [47:0]        last_time_r;
  logic signed [31:0] sd_r, d1_r, d2_r, force_r;
  logic signed [31:0] spike_r, len_r, vel_r, h_r, drive_r, out_r;
  logic signed [48:0] dt_r;
  logic signed [65:0] prod_r, acc_r, acc_nxt;
  logic [16:0]        lw_r, lw_nxt;
  logic [47:0]        dv_r;
  logic               neg_r;

  logic signed [32:0] ma_op, mb_op;
  logic [48:0]        mb;
  logic [40:0]        ma;
  logic [26:0]        div_lo;
  logic signed [31:0] h_val, drive_val, force_val;
  logic signed [48:0] num;
  logic [48:0]        num_mag;
  logic signed [39:0] w;

  function automatic logic signed [31:0] rnd_sat(input logic signed [65:0] v,
                                                  input logic [5:0] n);
    logic        neg;
    logic [65:0] m;
    logic [65:0] q;
    neg = v[65];
    m   = neg ? 66'(-v) : 66'(v);
    q   = (m + (66'd1 << (n - 6'd1))) >> n;
    if (!neg) rnd_sat = (q > 66'h7FFFFFFF) ? SMAX : 32'(q);
    else rnd_sat = (q > 66'h80000000) ? SMIN : 32'(-q);
  endfunction

  assign mb = dt_r[48] ? 49'(-dt_r) : 49'(dt_r);
  assign ma = dv_r[40:0];
  // dividend stays below 2^46
  assign div_lo = 27'({dv_r[45:24], 4'b0000}) + 27'(dv_r[23:0]);

  always_comb begin
    ma_op = '0;
    mb_op = '0;
    case (cmd.step)
      ST_T1: begin ma_op = TW_B1;  mb_op = 33'(sd_r); end
      ST_T2: begin ma_op = TW_2A;  mb_op = 33'(d1_r); end
      ST_T3: begin ma_op = TW_ASQ; mb_op = 33'(d2_r); end
      ST_T4: begin ma_op = 33'(len_r); mb_op = 33'(len_r); end
      ST_T6: begin ma_op = 33'(h_r); mb_op = {16'd0, lw_r}; end
      ST_D1: begin ma_op = {6'd0, div_lo}; mb_op = DIV_RCP; end
      ST_D2: begin ma_op = {11'd0, dv_r[45:24]}; mb_op = DIV_CHUNK; end
      ST_I1: begin ma_op = {12'd0, ma[20:0]}; mb_op = {17'd0, mb[15:0]}; end
      ST_I2: begin ma_op = {13'd0, ma[40:21]}; mb_op = {17'd0, mb[15:0]}; end
      ST_I3: begin ma_op = {12'd0, ma[20:0]}; mb_op = {17'd0, mb[31:16]}; end
      ST_I4: begin ma_op = {13'd0, ma[40:21]}; mb_op = {17'd0, mb[31:16]}; end
      ST_I5: begin ma_op = {12'd0, ma[20:0]}; mb_op = {16'd0, mb[48:32]}; end
      ST_I6: begin ma_op = {13'd0, ma[40:21]}; mb_op = {16'd0, mb[48:32]}; end
      default: ;
    endcase
  end

  always_comb begin
    h_val     = rnd_sat(acc_r, 6'd30);
    drive_val = rnd_sat(prod_r, 6'd16);
    num = 49'sd136 * ((len_r > 32'sd65536 ? 49'sd75 * (49'(len_r) - 49'sd65536) : 49'sd0)
          + 49'sd50 * 49'(vel_r) + 49'(drive_r)) - 49'sd211 * 49'(force_r);
    num_mag = num[48] ? 49'(-num) : 49'(num);
    if (len_r < 32'sd32768 || len_r >= 32'sd131072) w = '0;
    else if (len_r < 32'sd65536)
      w = -(40'(prod_r[35:0]) <<< 2) + (40'(len_r) <<< 19) - (40'sd3 <<< 32);
    else w = -40'(prod_r[35:0]) + (40'(len_r) <<< 17);
    lw_nxt = w[39] ? 17'd0 : 17'((40'(w) + 40'sd32768) >>> 16);
    acc_nxt = acc_r;
    case (cmd.step)
      ST_T2: acc_nxt = prod_r;
      ST_T3: acc_nxt = acc_r + prod_r;
      ST_T4: acc_nxt = acc_r - prod_r;
      ST_I2: acc_nxt = prod_r + 66'sh80000000;
      ST_I3, ST_I5, ST_I7: acc_nxt = acc_r + (prod_r <<< 21);
      ST_I4, ST_I6: acc_nxt = (acc_r >>> 16) + prod_r;
      default: ;
    endcase
    force_val = force_r;
    begin
      logic signed [42:0] inc;
      logic signed [42:0] sum;
      inc = (acc_r > 66'sh10000000000) ? 43'sh10000000000 : 43'(acc_r);
      if (neg_r) inc = -inc;
      sum = 43'(force_r) + inc;
      force_val = (sum > 43'sh7FFFFFFF) ? SMAX :
                  (sum < -43'sh80000000) ? SMIN : 32'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r <= '0;
      sd_r        <= '0;
      d1_r        <= '0;
      d2_r        <= '0;
      force_r     <= '0;
    end else begin
      if (cmd.load) last_time_r <= in_sample_time;
      if (cmd.step == ST_T5) begin
        sd_r <= spike_r;
        d1_r <= h_val;
        d2_r <= d1_r;
      end
      if (cmd.store) force_r <= force_val;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= ma_op * mb_op;
    acc_r  <= acc_nxt;
    if (cmd.load) begin
      spike_r <= in_spike_in;
      len_r   <= in_muscle_length;
      vel_r   <= in_length_velocity;
      dt_r    <= 49'({1'b0, in_sample_time}) - 49'({1'b0, last_time_r});
    end
    if (cmd.step == ST_T5) begin
      h_r  <= h_val;
      lw_r <= lw_nxt;
    end
    if (cmd.step == ST_T7) drive_r <= drive_val;
    if (cmd.step == ST_T8) begin
      dv_r  <= 48'(num_mag + 49'd25);
      neg_r <= num[48] ^ dt_r[48];
    end
    // quotient of the low part, then add hi * DIV_CHUNK
    if (cmd.step == ST_D2) dv_r <= 48'(prod_r[65:33]);
    if (cmd.step == ST_D3) dv_r <= dv_r + prod_r[47:0];
    if (cmd.store) out_r <= force_val;
  end

  assign out_muscle_force = out_r;

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for hill_muscle_force_step: directed table then random samples,
// each force checked against a cycle-free twitch/Hill force predictor
// or a typed row's value. Depends on hmf_pkg and the hill_muscle_force_step RTL.
`timescale 1ns / 1ps
module tb;
  import hmf_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_spike_in = '0;
  logic signed [31:0] in_muscle_length = '0;
  logic signed [31:0] in_length_velocity = '0;
  logic [47:0]        in_sample_time = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_muscle_force;

  hill_muscle_force_step DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  typedef struct {
    logic signed [31:0] spike;
    logic signed [31:0] len;
    logic signed [31:0] vel;
    logic [47:0]        stamp;
    bit                 typed;
    logic signed [31:0] force_val;
  } sample_row_t;

  logic [47:0]        prev_stamp;
  logic signed [31:0] drive_d, act_d1, act_d2, tension;
  logic signed [31:0] force_q[$];
  int                 errors = 0;
  int                 idle_pct = 0;
  int                 stall_pct = 0;
  int                 quiet_cycles = 0;
  logic [47:0]        clock_now = '0;

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_shift(input longint v, input int n);
    longint unsigned m;
    m = (v < 0) ? -v : v;
    m = (m + (64'd1 << (n - 1))) >> n;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint length_gain(input longint x);
    longint w;
    if (x < 32768 || x >= 131072) return 0;
    if (x < 65536) w = -4 * x * x + 8 * x * 65536 - 3 * 64'sd65536 * 65536;
    else w = -x * x + 2 * x * 65536;
    if (w < 0) w = 0;
    return (w + 32768) >>> 16;
  endfunction

  function automatic longint force_increment(input longint dfor, input longint dt);
    longint unsigned ma, mb, acc;
    ma = (dfor < 0) ? -dfor : dfor;
    mb = (dt < 0) ? -dt : dt;
    if (ma == 0 || mb == 0) return 0;
    acc = ma * (mb & 64'hFFFF) + 64'h8000_0000;
    acc >>= 16;
    acc += ma * ((mb >> 16) & 64'hFFFF);
    acc >>= 16;
    acc += ma * ((mb >> 32) & 64'h1FFFF);
    if (acc > (64'd1 << 40)) acc = 64'd1 << 40;
    return ((dfor < 0) != (dt < 0)) ? -longint'(acc) : longint'(acc);
  endfunction

  function automatic logic signed [31:0] next_force(input logic signed [31:0] sp, len, vel,
                                                    input logic [47:0] stamp);
    longint dt, acc, h, drv, ela, num, dfor;
    dt = longint'({16'd0, stamp}) - longint'({16'd0, prev_stamp});
    prev_stamp = stamp;
    acc = 64'sd2822753 * longint'(drive_d) + 64'sd2077080760 * longint'(act_d1)
        - 64'sd1004492976 * longint'(act_d2);
    h = sat32(round_shift(acc, 30));
    act_d2 = act_d1;
    act_d1 = h[31:0];
    drive_d = sp;
    drv = sat32(round_shift(h * length_gain(longint'(len)), 16));
    ela = (len > 32'sh10000) ? 75 * (longint'(len) - 65536) : 0;
    num = 136 * (ela + 50 * longint'(vel) + drv) - 211 * longint'(tension);
    dfor = (num >= 0) ? (num + 25) / 50 : -((-num + 25) / 50);
    tension = 32'(sat32(longint'(tension) + force_increment(dfor, dt)));
    return tension;
  endfunction

  task automatic send_beat(input sample_row_t r);
    logic signed [31:0] f;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_spike_in        <= r.spike;
    in_muscle_length   <= r.len;
    in_length_velocity <= r.vel;
    in_sample_time     <= r.stamp;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    f = next_force(r.spike, r.len, r.vel, r.stamp);
    force_q.push_back(r.typed ? r.force_val : f);
    @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (force_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  always @(negedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      if (force_q.size() == 0) begin
        $display("%0t: unexpected force beat, actual %h", $time, out_muscle_force);
        errors++;
      end else begin
        if (force_q[0] !== out_muscle_force) begin
          $display("%0t: muscle_force expected %h actual %h", $time, force_q[0],
                   out_muscle_force);
          errors++;
        end
        void'(force_q.pop_front());
      end
    end
  end

  sample_row_t directed[$];

  task automatic add_row(input logic signed [31:0] sp, len, vel, input logic [47:0] st,
                         input bit typed = 0, input logic signed [31:0] fv = 0);
    sample_row_t r;
    r = '{sp, len, vel, st, typed, fv};
    directed.push_back(r);
  endtask

  function automatic logic signed [31:0] rand_small(input int span);
    return $signed($urandom_range(2 * span)) - span;
  endfunction

  initial begin
    sample_row_t r;
    int sets[4][2];
    prev_stamp = '0; drive_d = '0; act_d1 = '0; act_d2 = '0; tension = '0;
    sets = '{'{0, 0}, '{72, 0}, '{0, 72}, '{38, 38}};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(0, 0, 0, 48'h0, 1, 32'sh0);
    add_row(0, 0, 32'sh7FFFFFFF, 48'h1_0000_0000, 1, 32'sh7FFFFFFF);
    add_row(0, 0, 32'sh80000000, 48'h2_0000_0000, 1, 32'sh80000000);
    add_row(32'sh7FFFFFFF, 32'sh10000, 0, 48'h2_0100_0000);
    add_row(32'sh80000000, 32'sh8000, 0, 48'h2_0200_0000);
    add_row(32'sh10000, 32'shC000, 0, 48'h2_0300_0000);
    add_row(32'sh10000, 32'sh18000, 32'sh100, 48'h2_0400_0000);
    add_row(32'sh7FFFFFFF, 32'sh20000, 0, 48'h2_0500_0000);
    add_row(32'sh7FFFFFFF, 32'sh1FFFF, 0, 48'h2_0600_0000);
    add_row(32'sh7FFFFFFF, 32'sh7FFF, 0, 48'h2_0700_0000);
    add_row(0, 32'sh80000000, 32'shFFFF0000, 48'h2_0800_0000);
    add_row(0, 32'sh7FFFFFFF, 0, 48'h1_0000_0000);
    add_row(32'sh55555555, 32'sh12345, 32'shAAAAAAAA, 48'hFFFF_FFFF_FFFF);
    add_row(32'shAAAAAAAA, 32'shF000, 32'sh55555555, 48'h0);
    add_row(32'sh10000, 32'sh10000, 32'sh10000, 48'h0);
    add_row(32'sh10000, 32'sh14000, 0, 48'h0_0100_0000);
    foreach (directed[i]) send_beat(directed[i]);
    clock_now = 48'h0_0100_0000;
    drain();

    foreach (sets[p]) begin
      idle_pct  = sets[p][0];
      stall_pct = sets[p][1];
      repeat (310) begin
        if ($urandom_range(99) < 80) begin
          clock_now += 48'($urandom_range(32'h80_0000));
          r.spike = ($urandom_range(3) == 0) ? $signed($urandom()) : rand_small(32'h20000);
          r.len   = 32'sh8000 + $urandom_range(32'h18000);
          r.vel   = rand_small(32'h40000);
          r.stamp = clock_now;
        end else begin
          r.spike = $urandom();
          r.len   = $urandom();
          r.vel   = $urandom();
          r.stamp = {16'($urandom_range(16'hFFFF)), $urandom()};
          clock_now = r.stamp;
        end
        r.typed = 0;
        r.force_val = 0;
        send_beat(r);
      end
      drain();
    end

    idle_pct = 0;
    stall_pct = 0;
    drain();
    repeat (60) @(posedge clk);
    if (errors == 0 && force_q.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
